[hdl/text_console_writer_unit_macros.svh]
// Assertion macros shared by the console writer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// condition holds at every clock edge out of reset
`define TCW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TCW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/tcw_pkg.sv]
// Shared types and constants of the text console writer.
// No dependencies; used by every module of the block but tcw_ram.
`default_nettype none

package tcw_pkg;

   localparam int MEMORY_CELLS = 8192;
   localparam int ADDR_W       = 13;
   localparam int CELL_W       = 16;
   localparam int CHAR_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int ACTION_W     = 2;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 48;
   localparam int QUEUE_DEPTH  = 2;   // power of two, pointers wrap naturally

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_BELL,
      CMD_BACKSPACE,
      CMD_LF_CR,
      CMD_LF,
      CMD_CR,
      CMD_BLANK,
      CMD_PRINT,
      CMD_READ,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [CHAR_W-1:0]         byte_value;
      logic [ADDR_W-1:0]         cell_address;
      logic                      publish;
   } cmd_type;

   // packed from the top bit down: read_data ends up in the lowest bits
   typedef struct packed {
      logic                      beep;
      logic [ADDR_W-1:0]         start_register;
      logic [ADDR_W-1:0]         cursor_register;
      logic [CELL_W-1:0]         read_data;
   } rsp_type;

   localparam int RSP_PAD_W = RSP_DATA_W - $bits(rsp_type);

endpackage

`default_nettype wire

[hdl/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read returns old data on a same-address write.
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/tcw_queue.sv]
// Short command queue between the front classifier and the back sequencer.
// Depends on tcw_pkg for the command type and the depth.
`default_nettype none
`include "text_console_writer_unit_macros.svh"

module tcw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcw_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output tcw_pkg::cmd_type pop_cmd,
   output logic             empty
);

   localparam int PTR_W = $clog2(tcw_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(tcw_pkg::QUEUE_DEPTH);

   tcw_pkg::cmd_type entries_ff [tcw_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `TCW_ASSERT_IMPLY(a_queue_no_overflow, clock, reset, push, !full, "push into full queue")
   `TCW_ASSERT_IMPLY(a_queue_no_underflow, clock, reset, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

[hdl/tcw_front.sv]
// Front end: accepts request transactions and classifies them into commands.
// Depends on tcw_pkg for the command type and field widths.
`default_nettype none

module tcw_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tcw_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [tcw_pkg::ACTION_W-1:0]       req_tuser,
   input  logic                               req_tlast,
   input  logic                               full,
   output logic                               push,
   output tcw_pkg::cmd_type                   cmd
);

   localparam logic [tcw_pkg::ACTION_W-1:0] ACT_PUT   = tcw_pkg::ACTION_W'(0);
   localparam logic [tcw_pkg::ACTION_W-1:0] ACT_READ  = tcw_pkg::ACTION_W'(1);
   localparam logic [tcw_pkg::ACTION_W-1:0] ACT_CLEAR = tcw_pkg::ACTION_W'(2);

   localparam logic [tcw_pkg::CHAR_W-1:0] CH_NUL = 8'h00;
   localparam logic [tcw_pkg::CHAR_W-1:0] CH_BEL = 8'h07;
   localparam logic [tcw_pkg::CHAR_W-1:0] CH_BS  = 8'h08;
   localparam logic [tcw_pkg::CHAR_W-1:0] CH_HT  = 8'h09;
   localparam logic [tcw_pkg::CHAR_W-1:0] CH_LF  = 8'h0A;
   localparam logic [tcw_pkg::CHAR_W-1:0] CH_VT  = 8'h0B;
   localparam logic [tcw_pkg::CHAR_W-1:0] CH_FF  = 8'h0C;
   localparam logic [tcw_pkg::CHAR_W-1:0] CH_CR  = 8'h0D;
   localparam logic [tcw_pkg::CHAR_W-1:0] CH_SI  = 8'h0F;

   logic [tcw_pkg::CHAR_W-1:0] byte_value;
   logic [tcw_pkg::ADDR_W-1:0] cell_address;

   assign byte_value   = req_tdata[tcw_pkg::CHAR_W-1:0];
   assign cell_address = req_tdata[tcw_pkg::CHAR_W +: tcw_pkg::ADDR_W];

   assign req_tready = !full;
   assign push       = req_tvalid && !full;

   always_comb begin
      cmd.byte_value   = byte_value;
      cmd.cell_address = cell_address;
      cmd.publish      = 1'b0;
      cmd.kind         = tcw_pkg::CMD_NOP;
      unique case (req_tuser)
         ACT_PUT: begin
            cmd.publish = req_tlast;
            unique case (byte_value)
               CH_NUL, CH_HT, CH_VT: cmd.kind = tcw_pkg::CMD_NOP;
               CH_BEL:               cmd.kind = tcw_pkg::CMD_BELL;
               CH_BS:                cmd.kind = tcw_pkg::CMD_BACKSPACE;
               CH_LF:                cmd.kind = tcw_pkg::CMD_LF_CR;
               CH_FF:                cmd.kind = tcw_pkg::CMD_LF;
               CH_CR:                cmd.kind = tcw_pkg::CMD_CR;
               CH_SI:                cmd.kind = tcw_pkg::CMD_BLANK;
               default:              cmd.kind = tcw_pkg::CMD_PRINT;
            endcase
         end
         ACT_READ:  cmd.kind = tcw_pkg::CMD_READ;
         ACT_CLEAR: cmd.kind = tcw_pkg::CMD_CLEAR;
         default:   cmd.kind = tcw_pkg::CMD_NOP;   // unused action: plain status answer
      endcase
   end

endmodule

`default_nettype wire

[hdl/tcw_back.sv]
// Back end: sequencer that executes commands against the cell RAM and
// holds cursor, window and configuration state. Depends on tcw_pkg, tcw_ram.
`default_nettype none
`include "text_console_writer_unit_macros.svh"

module tcw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  tcw_pkg::cmd_type                   q_cmd,
   output logic                               q_pop,
   input  logic                               csr_valid,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tcw_pkg::rsp_type                   rsp
);

   localparam int AW           = tcw_pkg::ADDR_W;
   localparam int COL_W        = $clog2(COLUMNS + 1);
   localparam int ROW_W        = $clog2(ROWS);
   localparam int CNT_W        = $clog2(tcw_pkg::MEMORY_CELLS + 1);
   localparam int SUM_W        = AW + 2;
   localparam int SCREEN_CELLS = COLUMNS * ROWS;

   localparam logic [AW-1:0]    COLS_STEP   = AW'(COLUMNS);
   localparam logic [AW-1:0]    SCREEN_STEP = AW'(SCREEN_CELLS);
   localparam logic [COL_W-1:0] COL_LIMIT   = COL_W'(COLUMNS);
   localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);
   localparam logic [SUM_W-1:0] SCROLL_SPAN = SUM_W'(SCREEN_CELLS + COLUMNS);
   localparam logic [SUM_W-1:0] MEM_LIMIT   = SUM_W'(tcw_pkg::MEMORY_CELLS);
   localparam logic [CNT_W-1:0] CLEAR_LAST  = CNT_W'(tcw_pkg::MEMORY_CELLS - 1);
   localparam logic [CNT_W-1:0] COPY_LAST   = CNT_W'(SCREEN_CELLS);
   localparam logic [CNT_W-1:0] ROW_LAST    = CNT_W'(COLUMNS - 1);

   localparam logic [tcw_pkg::CSR_INDEX_W-1:0] CSR_TEXT_ATTRIBUTE = tcw_pkg::CSR_INDEX_W'(0);
   localparam logic [tcw_pkg::CSR_INDEX_W-1:0] CSR_BLANK_CELL     = tcw_pkg::CSR_INDEX_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CLEAR,
      ST_COPY,
      ST_BLANK_ROW,
      ST_FINISH
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   tcw_pkg::cmd_kind_type       kind_ff, kind_in;
   logic [tcw_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic                        publish_ff, publish_in;
   logic [AW-1:0]               window_ff, window_in;
   logic [AW-1:0]               cursor_ff, cursor_in;
   logic [COL_W-1:0]            column_ff, column_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [AW-1:0]               shown_ff, shown_in;
   logic [tcw_pkg::ATTR_W-1:0]  attr_ff, attr_in;
   logic [tcw_pkg::CELL_W-1:0]  blank_ff, blank_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::CELL_W-1:0]  read_data_ff, read_data_in;
   logic                        beep_ff, beep_in;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [tcw_pkg::CELL_W-1:0]  wr_data;
   logic [AW-1:0]               rd_addr;
   logic [tcw_pkg::CELL_W-1:0]  rd_data;

   logic                        out_free;
   logic                        wrap_line;
   logic                        line_feed;
   logic                        scroll_copy;
   logic [AW-1:0]               cur_pre;
   logic [COL_W-1:0]            col_pre;
   logic                        finish;
   logic                        fin_beep;
   logic                        fin_publish;
   logic [tcw_pkg::CELL_W-1:0]  fin_data;
   logic                        do_tail;
   tcw_pkg::cmd_kind_type       tail_kind;
   logic [AW-1:0]               tail_cur;
   logic [COL_W-1:0]            tail_col;
   logic [tcw_pkg::CHAR_W-1:0]  tail_char;

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (tcw_pkg::MEMORY_CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      // printable byte past the last column: back up a row, then line feed
      wrap_line   = (q_cmd.kind == tcw_pkg::CMD_PRINT) && (column_ff >= COL_LIMIT);
      cur_pre     = wrap_line ? cursor_ff - COLS_STEP : cursor_ff;
      col_pre     = wrap_line ? column_ff - COL_LIMIT : column_ff;
      line_feed   = (q_cmd.kind == tcw_pkg::CMD_LF) || (q_cmd.kind == tcw_pkg::CMD_LF_CR) ||
                    wrap_line;
      // window close to the top of memory: move it back to cell 0 first
      scroll_copy = ({2'b00, window_ff} + SCROLL_SPAN) >= MEM_LIMIT;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      publish_in   = publish_ff;
      window_in    = window_ff;
      cursor_in    = cursor_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      shown_in     = shown_ff;
      attr_in      = attr_ff;
      blank_in     = blank_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      read_data_in = read_data_ff;
      beep_in      = beep_ff;

      q_pop       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = cursor_ff;
      wr_data     = blank_ff;
      rd_addr     = q_cmd.cell_address;
      finish      = 1'b0;
      fin_beep    = 1'b0;
      fin_publish = 1'b0;
      fin_data    = '0;
      do_tail     = 1'b0;
      tail_kind   = kind_ff;
      tail_cur    = cursor_ff;
      tail_col    = column_ff;
      tail_char   = char_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TEXT_ATTRIBUTE: attr_in  = csr_data[tcw_pkg::ATTR_W-1:0];
            CSR_BLANK_CELL:     blank_in = csr_data;
            default:            attr_in  = attr_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               unique case (q_cmd.kind)
                  tcw_pkg::CMD_NOP: begin
                     finish      = 1'b1;
                     fin_publish = q_cmd.publish;
                  end
                  tcw_pkg::CMD_BELL: begin
                     finish      = 1'b1;
                     fin_beep    = 1'b1;
                     fin_publish = q_cmd.publish;
                  end
                  tcw_pkg::CMD_BACKSPACE: begin
                     if (column_ff != '0) begin
                        column_in = column_ff - 1'b1;
                        cursor_in = cursor_ff - 1'b1;
                        wr_en     = 1'b1;
                        wr_addr   = cursor_ff - 1'b1;
                     end
                     finish      = 1'b1;
                     fin_publish = q_cmd.publish;
                  end
                  tcw_pkg::CMD_CR: begin
                     cursor_in   = cursor_ff - AW'(column_ff);
                     column_in   = '0;
                     finish      = 1'b1;
                     fin_publish = q_cmd.publish;
                  end
                  tcw_pkg::CMD_BLANK: begin
                     wr_en       = 1'b1;
                     finish      = 1'b1;
                     fin_publish = q_cmd.publish;
                  end
                  tcw_pkg::CMD_READ: begin
                     state_in = ST_READ;
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     window_in = '0;
                     cursor_in = '0;
                     column_in = '0;
                     row_in    = '0;
                     shown_in  = '0;
                     cnt_in    = '0;
                     state_in  = ST_CLEAR;
                  end
                  tcw_pkg::CMD_LF, tcw_pkg::CMD_LF_CR, tcw_pkg::CMD_PRINT: begin
                     kind_in    = q_cmd.kind;
                     char_in    = q_cmd.byte_value;
                     publish_in = q_cmd.publish;
                     if (line_feed && row_ff == LAST_ROW) begin
                        cursor_in = cur_pre;
                        column_in = col_pre;
                        cnt_in    = '0;
                        state_in  = scroll_copy ? ST_COPY : ST_BLANK_ROW;
                     end else begin
                        do_tail     = 1'b1;
                        tail_kind   = q_cmd.kind;
                        tail_char   = q_cmd.byte_value;
                        tail_col    = col_pre;
                        tail_cur    = cur_pre;
                        fin_publish = q_cmd.publish;
                        if (line_feed) begin
                           row_in   = row_ff + 1'b1;
                           tail_cur = cur_pre + COLS_STEP;
                        end
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            finish   = 1'b1;
            fin_data = rd_data;
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(cnt_ff);
            if (cnt_ff == CLEAR_LAST) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_COPY: begin
            // read source cell now, write the one read in the previous cycle
            rd_addr = window_ff + AW'(cnt_ff);
            if (cnt_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = AW'(cnt_ff - 1'b1);
               wr_data = rd_data;
            end
            if (cnt_ff == COPY_LAST) begin
               cursor_in = cursor_ff - window_ff;
               window_in = '0;
               cnt_in    = '0;
               state_in  = ST_BLANK_ROW;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_BLANK_ROW: begin
            wr_en   = 1'b1;
            wr_addr = window_ff + SCREEN_STEP + AW'(cnt_ff);
            if (cnt_ff == ROW_LAST) begin
               window_in = window_ff + COLS_STEP;
               cursor_in = cursor_ff + COLS_STEP;
               state_in  = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            do_tail     = 1'b1;
            fin_publish = publish_ff;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // tail of a line-feed or print command: carriage return, character write or cursor move
      if (do_tail) begin
         finish = 1'b1;
         unique case (tail_kind)
            tcw_pkg::CMD_LF_CR: begin
               cursor_in = tail_cur - AW'(tail_col);
               column_in = '0;
            end
            tcw_pkg::CMD_PRINT: begin
               wr_en     = 1'b1;
               wr_addr   = tail_cur;
               wr_data   = {attr_ff, tail_char};
               cursor_in = tail_cur + 1'b1;
               column_in = tail_col + 1'b1;
            end
            default: begin
               cursor_in = tail_cur;
               column_in = tail_col;
            end
         endcase
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
         read_data_in = fin_data;
         beep_in      = fin_beep;
         if (fin_publish) begin
            shown_in = cursor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         window_ff    <= '0;
         cursor_ff    <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         shown_ff     <= '0;
         attr_ff      <= tcw_pkg::ATTR_W'(7);
         blank_ff     <= tcw_pkg::CELL_W'(16'h0720);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         window_ff    <= window_in;
         cursor_ff    <= cursor_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         shown_ff     <= shown_in;
         attr_ff      <= attr_in;
         blank_ff     <= blank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      char_ff      <= char_in;
      publish_ff   <= publish_in;
      read_data_ff <= read_data_in;
      beep_ff      <= beep_in;
   end

   // No new command starts while a result is pending, so window and shown
   // cursor still match the pending result until it is taken.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp.read_data       = read_data_ff;
   assign rsp.cursor_register = shown_ff;
   assign rsp.start_register  = window_ff;
   assign rsp.beep            = beep_ff;

   `TCW_ASSERT_IMPLY(a_pop_needs_slot, clock, reset, q_pop, (!rsp_valid_ff || rsp_ready), "command started with result slot busy")
   `TCW_ASSERT_IMPLY(a_busy_no_rsp, clock, reset, (state_ff != ST_IDLE), !rsp_valid_ff, "result pending during multi-cycle command")
   `TCW_ASSERT_ALWAYS(a_column_range, clock, reset, (column_ff <= COL_LIMIT), "column beyond line length")
   `TCW_ASSERT_NEXT(a_copy_homes_window, clock, reset, (state_ff == ST_COPY && cnt_ff == COPY_LAST), (window_ff == '0 && state_ff == ST_BLANK_ROW), "window not homed after copy")

endmodule

`default_nettype wire

[hdl/text_console_writer_unit.sv]
// Throughput: one simple item per cycle while results are taken, set by the single-write
// cell RAM port. A read, a clear or a scroll holds later items until it finishes; a scroll
// blanks a new bottom row, after first copying the window to cell 0 when it is near the top
// of memory. Clear walks every cell. Reset is synchronous, active high: cursor, window,
// column, row go to 0, attribute to 0x07, blank cell to 0x0720; cell RAM content stays
// undefined until written (no clearing pass).
`default_nettype none

module text_console_writer_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] byte_value, [20:8] cell_address, [23:21] zero
   input  logic [tcw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] action
   input  logic [tcw_pkg::ACTION_W-1:0]       req_tuser,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] read_data, [28:16] cursor_register, [41:29] start_register,
   // [42] beep, [47:43] zero
   output logic [tcw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]     csr_data
);

   tcw_pkg::cmd_type push_cmd;
   tcw_pkg::cmd_type pop_cmd;
   tcw_pkg::rsp_type rsp;
   logic             push;
   logic             pop;
   logic             full;
   logic             empty;

   tcw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .full       (full),
      .push       (push),
      .cmd        (push_cmd)
   );

   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (empty)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (empty),
      .q_cmd     (pop_cmd),
      .q_pop     (pop),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // register writes land in the next cycle
   assign csr_ready = 1'b1;
   assign rsp_tdata = {{tcw_pkg::RSP_PAD_W{1'b0}}, rsp};

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer_unit: a directed table, then random text,
// scroll bursts and noise, checked against a cell-accurate console model; typed table rows
// carry their own expected results. Depends on tcw_pkg and the RTL of the block only.

module tb_top;

   import tcw_pkg::*;

   localparam int COLS         = 80;
   localparam int NROWS        = 25;
   localparam int SCREEN       = COLS * NROWS;
   localparam int CELLS        = MEMORY_CELLS;
   localparam int STALL_LIMIT  = 60000;   // must outlast a clear, which walks every cell
   localparam int SETTLE       = 16;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 215;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT,
      ACT_READ,
      ACT_CLEAR,
      ACT_UNKNOWN
   } console_action_t;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_ATTR  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLANK_CELL = 1'd1;

   localparam logic [7:0] BYTE_NUL  = 8'h00;
   localparam logic [7:0] BYTE_BELL = 8'h07;
   localparam logic [7:0] BYTE_BS   = 8'h08;
   localparam logic [7:0] BYTE_TAB  = 8'h09;
   localparam logic [7:0] BYTE_LF   = 8'h0A;
   localparam logic [7:0] BYTE_VT   = 8'h0B;
   localparam logic [7:0] BYTE_FF   = 8'h0C;
   localparam logic [7:0] BYTE_CR   = 8'h0D;
   localparam logic [7:0] BYTE_SI   = 8'h0F;

   localparam rsp_type NO_WANT = '0;

   typedef struct {
      console_action_t act;
      logic [7:0]      ch;
      logic [12:0]     addr;
      logic            last;
      bit              typed;
      rsp_type         want;
   } console_step_t;

   localparam int OPENING_ROWS = 22;

   // typed rows: {beep, start_register, cursor_register, read_data}
   console_step_t opening_steps [OPENING_ROWS] = '{
      '{ACT_PUT,     BYTE_NUL,  13'd0,    1'b1, 1'b1, '{1'b0, 13'd0, 13'd0, 16'h0000}},
      '{ACT_PUT,     8'h41,     13'd0,    1'b0, 1'b1, '{1'b0, 13'd0, 13'd0, 16'h0000}},
      '{ACT_READ,    8'h00,     13'd0,    1'b0, 1'b1, '{1'b0, 13'd0, 13'd0, 16'h0741}},
      '{ACT_CLEAR,   8'h00,     13'd0,    1'b0, 1'b1, '{1'b0, 13'd0, 13'd0, 16'h0000}},
      '{ACT_READ,    8'hFF,     13'h1FFF, 1'b1, 1'b1, '{1'b0, 13'd0, 13'd0, 16'h0720}},
      '{ACT_PUT,     BYTE_BELL, 13'd0,    1'b0, 1'b1, '{1'b1, 13'd0, 13'd0, 16'h0000}},
      '{ACT_PUT,     8'hFF,     13'h1FFF, 1'b1, 1'b0, NO_WANT},
      '{ACT_READ,    8'h00,     13'd0,    1'b0, 1'b1, '{1'b0, 13'd0, 13'd1, 16'h07FF}},
      '{ACT_PUT,     BYTE_BS,   13'd0,    1'b1, 1'b0, NO_WANT},
      '{ACT_PUT,     BYTE_BS,   13'd0,    1'b1, 1'b0, NO_WANT},
      '{ACT_PUT,     8'h01,     13'd0,    1'b0, 1'b0, NO_WANT},
      '{ACT_PUT,     BYTE_SI,   13'd0,    1'b1, 1'b0, NO_WANT},
      '{ACT_PUT,     BYTE_LF,   13'd0,    1'b1, 1'b0, NO_WANT},
      '{ACT_PUT,     8'h20,     13'd0,    1'b0, 1'b0, NO_WANT},
      '{ACT_PUT,     BYTE_FF,   13'd0,    1'b1, 1'b0, NO_WANT},
      '{ACT_PUT,     BYTE_CR,   13'd0,    1'b1, 1'b0, NO_WANT},
      '{ACT_PUT,     BYTE_TAB,  13'h1FFF, 1'b1, 1'b0, NO_WANT},
      '{ACT_PUT,     BYTE_VT,   13'd0,    1'b0, 1'b0, NO_WANT},
      '{ACT_PUT,     8'h80,     13'd0,    1'b1, 1'b0, NO_WANT},
      '{ACT_UNKNOWN, 8'hFF,     13'h1FFF, 1'b1, 1'b0, NO_WANT},
      '{ACT_READ,    8'h00,     13'd80,   1'b0, 1'b0, NO_WANT},
      '{ACT_READ,    8'h00,     13'd160,  1'b0, 1'b0, NO_WANT}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [ACTION_W-1:0]    req_tuser = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // console model state
   logic [15:0]  cell_mem [0:CELLS-1];
   int unsigned  win_start, cur_cell, col, row_idx, shown_cur;
   logic [7:0]   attr_q  = 8'h07;
   logic [15:0]  blank_q = 16'h0720;

   rsp_type      pending_rsp [$];
   int           failures;
   int           stalled_cycles;
   int           items_sent;
   bit           calm;
   int           n_puts, n_reads, n_clears, n_scrolls, n_copies, n_beeps, n_wraps, n_csr;

   text_console_writer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned cell_back(int unsigned v, int unsigned k);
      return (v + CELLS - (k % CELLS)) % CELLS;
   endfunction

   function automatic bit is_control(logic [7:0] b);
      return b inside {BYTE_NUL, BYTE_BELL, BYTE_BS, BYTE_TAB, BYTE_LF, BYTE_VT,
                       BYTE_FF, BYTE_CR, BYTE_SI};
   endfunction

   function automatic logic [7:0] printable_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (is_control(b));
      return b;
   endfunction

   function automatic void line_feed();
      if (row_idx + 1 < NROWS) begin
         row_idx++;
         cur_cell = (cur_cell + COLS) % CELLS;
         return;
      end
      // bottom row: scroll, moving the window back to cell 0 when near the top of memory
      if (win_start + SCREEN + COLS >= CELLS) begin
         for (int i = 0; i < SCREEN; i++)
            cell_mem[i] = cell_mem[(win_start + i) % CELLS];
         cur_cell = cell_back(cur_cell, win_start);
         win_start = 0;
         n_copies++;
      end
      for (int i = 0; i < COLS; i++)
         cell_mem[(win_start + SCREEN + i) % CELLS] = blank_q;
      win_start = (win_start + COLS) % CELLS;
      cur_cell = (cur_cell + COLS) % CELLS;
      n_scrolls++;
   endfunction

   function automatic rsp_type predict_console(console_action_t act, logic [7:0] ch,
                                               logic [12:0] addr, logic last);
      rsp_type r;
      r = '0;
      case (act)
         ACT_PUT: begin
            n_puts++;
            case (ch)
               BYTE_NUL, BYTE_TAB, BYTE_VT: ;
               BYTE_BELL: begin
                  r.beep = 1'b1;
                  n_beeps++;
               end
               BYTE_BS: begin
                  if (col != 0) begin
                     col--;
                     cur_cell = cell_back(cur_cell, 1);
                     cell_mem[cur_cell] = blank_q;
                  end
               end
               BYTE_LF: begin
                  line_feed();
                  cur_cell = cell_back(cur_cell, col);
                  col = 0;
               end
               BYTE_FF: line_feed();
               BYTE_CR: begin
                  cur_cell = cell_back(cur_cell, col);
                  col = 0;
               end
               BYTE_SI: cell_mem[cur_cell] = blank_q;
               default: begin
                  if (col >= COLS) begin
                     col -= COLS;
                     cur_cell = cell_back(cur_cell, COLS);
                     line_feed();
                     n_wraps++;
                  end
                  cell_mem[cur_cell] = {attr_q, ch};
                  cur_cell = (cur_cell + 1) % CELLS;
                  col++;
               end
            endcase
            if (last)
               shown_cur = cur_cell;
         end
         ACT_READ: begin
            r.read_data = cell_mem[addr];
            n_reads++;
         end
         ACT_CLEAR: begin
            win_start = 0;
            cur_cell = 0;
            col = 0;
            row_idx = 0;
            shown_cur = 0;
            for (int i = 0; i < CELLS; i++)
               cell_mem[i] = blank_q;
            n_clears++;
         end
         default: ;
      endcase
      r.cursor_register = shown_cur[12:0];
      r.start_register = win_start[12:0];
      return r;
   endfunction

   // one request transaction; entered and left at a rising edge
   task automatic send_item(console_action_t act, logic [7:0] ch, logic [12:0] addr,
                            logic last, bit typed, rsp_type want);
      int unsigned gap;
      rsp_type     predicted;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, addr, ch};
      req_tuser <= act;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_console(act, ch, addr, last);
      pending_rsp.push_back(typed ? want : predicted);
      if (!(act == ACT_UNKNOWN || (act == ACT_PUT && ch inside {BYTE_NUL, BYTE_TAB, BYTE_VT})))
         items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(logic [7:0] attr, logic [15:0] blank);
      csr_valid <= 1'b1;
      csr_index <= CSR_TEXT_ATTR;
      csr_data <= {8'h00, attr};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      attr_q = attr;
      csr_index <= CSR_BLANK_CELL;
      csr_data <= blank;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      blank_q = blank;
      csr_valid <= 1'b0;
      n_csr += 2;
   endtask

   task automatic random_put(logic [7:0] ch, logic last);
      send_item(ACT_PUT, ch, 13'($urandom_range(0, CELLS - 1)), last, 1'b0, NO_WANT);
   endtask

   // one well-formed run (text line or line-feed burst) or a few noise transactions
   task automatic run_sequence();
      int unsigned kind, len, pick;
      logic [7:0]  ch;
      logic [12:0] addr;
      kind = $urandom_range(0, 99);
      calm = ($urandom_range(0, 5) == 0);
      if (kind < 35) begin
         len = $urandom_range(20, 60);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            ch = (pick < 85) ? ((pick % 2 == 0) ? BYTE_LF : BYTE_FF) : printable_byte();
            random_put(ch, (i == len - 1) || ($urandom_range(0, 7) == 0));
         end
      end else if (kind < 80) begin
         len = $urandom_range(0, 100);
         pick = $urandom_range(0, 3);
         for (int i = 0; i < len; i++) begin
            ch = ($urandom_range(0, 99) < 8) ? BYTE_BS : printable_byte();
            random_put(ch, (i == len - 1) && (pick == 3));
         end
         case (pick)
            0: random_put(BYTE_LF, 1'b1);
            1: begin
               random_put(BYTE_CR, 1'b0);
               random_put(BYTE_LF, 1'b1);
            end
            2: random_put(BYTE_FF, 1'b1);
            default: ;
         endcase
      end else begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               send_item(ACT_CLEAR, 8'($urandom_range(0, 255)),
                         13'($urandom_range(0, CELLS - 1)), 1'($urandom_range(0, 1)),
                         1'b0, NO_WANT);
            end else if (pick < 58) begin
               // memory is fully written since the opening clear
               case ($urandom_range(0, 4))
                  0, 1: addr = 13'($urandom_range(0, CELLS - 1));
                  2, 3: addr = 13'(cell_back(cur_cell, $urandom_range(0, 160)));
                  default: addr = 13'((win_start + $urandom_range(0, SCREEN - 1)) % CELLS);
               endcase
               send_item(ACT_READ, 8'($urandom_range(0, 255)), addr,
                         1'($urandom_range(0, 1)), 1'b0, NO_WANT);
            end else if (pick < 65) begin
               send_item(ACT_UNKNOWN, 8'($urandom_range(0, 255)),
                         13'($urandom_range(0, CELLS - 1)), 1'($urandom_range(0, 1)),
                         1'b0, NO_WANT);
            end else begin
               random_put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
            end
         end
      end
   endtask

   // result side: random back-pressure and in-order compare
   always @(posedge clock) begin : rsp_pace
      int unsigned pause;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         pause = calm ? 0 : $urandom_range(0, 11);
         rsp_tready <= (pause == 0);
         stall_left <= pause;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   int unsigned stall_left = 0;

   always @(posedge clock) begin : rsp_check
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
         if (pending_rsp.size() == 0) begin
            $error("result transaction with nothing pending: %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, got.read_data);
               failures++;
            end
            if (got.cursor_register !== want.cursor_register) begin
               $error("cursor_register: expected %0d, got %0d",
                      want.cursor_register, got.cursor_register);
               failures++;
            end
            if (got.start_register !== want.start_register) begin
               $error("start_register: expected %0d, got %0d",
                      want.start_register, got.start_register);
               failures++;
            end
            if (got.beep !== want.beep) begin
               $error("beep: expected %b, got %b", want.beep, got.beep);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("text_console_writer_unit verification failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // opening table runs on the reset register values
      foreach (opening_steps[i])
         send_item(opening_steps[i].act, opening_steps[i].ch, opening_steps[i].addr,
                   opening_steps[i].last, opening_steps[i].typed, opening_steps[i].want);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         case (ph)
            0: configure(8'h00, 16'h0000);
            1: configure(8'hFF, 16'hFFFF);
            2: configure(8'h07, 16'h0720);
            default: configure(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
         endcase
         begin : phase_body
            int start_count;
            start_count = items_sent;
            while (items_sent - start_count < PHASE_ITEMS) run_sequence();
         end
      end

      drain_results();
      $display("covered %0d puts, %0d reads, %0d clears, %0d beeps, %0d wraps, %0d csr writes",
               n_puts, n_reads, n_clears, n_beeps, n_wraps, n_csr);
      $display("scrolled %0d times with %0d window copies to cell 0", n_scrolls, n_copies);
      if (failures == 0)
         $display("text_console_writer_unit verification clean");
      else
         $display("text_console_writer_unit verification failed");
      $finish;
   end

endmodule
